// File: design/e2d_pkg.sv
`default_nettype none

package e2d_pkg;

    localparam int ALU_W   = 18;
    localparam int REM_W   = 17;
    localparam int DAY_W   = 16;
    localparam int OFS_W   = 8;
    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 26;
    localparam int MUL_P_W = 51;

    // Division by a constant: q = (x * RECIP) >> Q_LSB, exact over the range each step sees.
    // Day and hour dividends are pre-shifted by the divisor's power of two, the minute one by 4.
    localparam logic [MUL_B_W-1:0] DAY_RECIP  = 26'd50903317;
    localparam logic [MUL_B_W-1:0] WEEK_RECIP = 26'd74899;
    localparam logic [MUL_B_W-1:0] HOUR_RECIP = 26'd9321;
    localparam logic [MUL_B_W-1:0] MIN_RECIP  = 26'd1093;
    localparam int                 DAY_Q_LSB  = 35;
    localparam int                 WEEK_Q_LSB = 19;
    localparam int                 HOUR_Q_LSB = 21;
    localparam int                 MIN_Q_LSB  = 14;

    // Divisors for the multiply-back that yields each remainder
    localparam logic [MUL_B_W-1:0] DAY_LEN_S     = 26'd86400;
    localparam logic [MUL_B_W-1:0] HOUR_LEN_S    = 26'd3600;
    localparam logic [MUL_B_W-1:0] MIN_LEN_S     = 26'd60;
    localparam logic [MUL_B_W-1:0] DAYS_PER_WEEK = 26'd7;

    // 2000-01-01 was a Saturday: a day count that is a multiple of seven is a Saturday,
    // otherwise the remainder is the weekday itself
    localparam logic [2:0]       WDAY_SAT     = 3'd7;
    localparam logic [11:0]      BASE_YEAR    = 12'd2000;
    localparam logic [8:0]       DAYS_COMMON  = 9'd365;
    localparam logic [8:0]       DAYS_LEAP    = 9'd366;
    localparam logic [OFS_W-1:0] YEAR_OFS_MAX = 8'd136;
    localparam logic [3:0]       MON_FEB      = 4'd1;
    localparam logic [3:0]       LAST_MONTH   = 4'd11;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DAY_BACK,
        S_DAY_REM,
        S_WDAY_BACK,
        S_WDAY_REM,
        S_HOUR_BACK,
        S_HOUR_REM,
        S_MIN_QUO,
        S_MIN_BACK,
        S_MIN_REM,
        S_YEAR,
        S_MONTH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             ge;
        logic [ALU_W-1:0] diff;
    } t_alu_res;

    // Year as an offset from 2000: the only centuries in reach are 2000 (leap)
    // and 2100 (not leap)
    function automatic logic is_leap(input logic [OFS_W-1:0] ofs);
        return (ofs[1:0] == 2'b00) && (ofs != 8'd100) && (ofs != 8'd200);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        unique case (mon)
            MON_FEB: len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd30;
            4'd5:    len = 5'd30;
            4'd8:    len = 5'd30;
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// File: design/e2d_in_if.sv
`default_nettype none

interface e2d_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] epoch_secs;

    modport source (output valid, output epoch_secs, input ready);
    modport sink   (input valid, input epoch_secs, output ready);
endinterface

`default_nettype wire

// File: design/e2d_out_if.sv
`default_nettype none

interface e2d_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  sec;
    logic [2:0]  weekday;

    modport source (
        output valid, output year, output month, output day, output hour,
        output minute, output sec, output weekday, input ready
    );
    modport sink (
        input valid, input year, input month, input day, input hour,
        input minute, input sec, input weekday, output ready
    );
endinterface

`default_nettype wire

// File: design/epoch_seconds_to_date_top.sv
// Sequence: from accept, the day, weekday, hour and minute divisions, then a walk over the
//   whole years passed and one over the months passed (to December at most), then hand-over.
// One item at a time: a new input is taken only in idle, once the last result is handed over.
// The result waits in an output register; a stalled output holds the sequencer in hand-over
//   only while that register is still full.
// Reset (synchronous, active low) returns the sequencer to idle and drops the result valid.
`default_nettype none

module epoch_seconds_to_date_top import e2d_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    e2d_in_if.sink     i_in,
    e2d_out_if.source  o_out
);

    t_state             r_state, n_state;
    logic [REM_W-1:0]   r_secs;
    logic [MUL_P_W-1:0] r_prod;
    logic [REM_W-1:0]   r_rem;
    logic [DAY_W-1:0]   r_days;
    logic [OFS_W-1:0]   r_ofs;
    logic [3:0]         r_mon;
    logic [4:0]         r_hour;
    logic [5:0]         r_min;
    logic [5:0]         r_sec;
    logic [2:0]         r_wday;

    logic               r_o_valid;
    logic [11:0]        r_o_year;
    logic [3:0]         r_o_month;
    logic [4:0]         r_o_day;
    logic [4:0]         r_o_hour;
    logic [5:0]         r_o_min;
    logic [5:0]         r_o_sec;
    logic [2:0]         r_o_wday;

    logic [ALU_W-1:0]   alu_a, alu_b;
    t_alu_res           alu_res;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;
    logic               leap;
    logic               out_free;
    logic               load_out;

    assign leap      = is_leap(r_ofs);
    assign out_free  = !r_o_valid || o_out.ready;
    assign load_out  = (r_state == S_DONE) && out_free;

    assign i_in.ready = (r_state == S_IDLE);

    // Operand select for the shared unit: quotient by reciprocal, multiply back, subtract
    always_comb begin
        alu_a = '0;
        alu_b = '0;
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_IDLE: begin
                mul_a = i_in.epoch_secs[31:7];
                mul_b = DAY_RECIP;
            end
            S_DAY_BACK: begin
                mul_a = {9'd0, r_prod[DAY_Q_LSB +: DAY_W]};
                mul_b = DAY_LEN_S;
            end
            S_DAY_REM: begin
                alu_a = {1'b0, r_secs};
                alu_b = {1'b0, r_prod[REM_W-1:0]};
                mul_a = {9'd0, r_days};
                mul_b = WEEK_RECIP;
            end
            S_WDAY_BACK: begin
                mul_a = {11'd0, r_prod[WEEK_Q_LSB +: 14]};
                mul_b = DAYS_PER_WEEK;
            end
            S_WDAY_REM: begin
                alu_a = {15'd0, r_days[2:0]};
                alu_b = {15'd0, r_prod[2:0]};
                mul_a = {12'd0, r_rem[16:4]};
                mul_b = HOUR_RECIP;
            end
            S_HOUR_BACK: begin
                mul_a = {20'd0, r_prod[HOUR_Q_LSB +: 5]};
                mul_b = HOUR_LEN_S;
            end
            S_HOUR_REM: begin
                alu_a = {6'd0, r_rem[11:0]};
                alu_b = {6'd0, r_prod[11:0]};
            end
            S_MIN_QUO: begin
                mul_a = {15'd0, r_rem[11:2]};
                mul_b = MIN_RECIP;
            end
            S_MIN_BACK: begin
                mul_a = {19'd0, r_prod[MIN_Q_LSB +: 6]};
                mul_b = MIN_LEN_S;
            end
            S_MIN_REM: begin
                alu_a = {12'd0, r_rem[5:0]};
                alu_b = {12'd0, r_prod[5:0]};
            end
            S_YEAR: begin
                alu_a = {2'b00, r_days};
                alu_b = {9'd0, leap ? DAYS_LEAP : DAYS_COMMON};
            end
            S_MONTH: begin
                alu_a = {2'b00, r_days};
                alu_b = {13'd0, month_len(r_mon, leap)};
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    e2d_alu u_alu (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_mul_a (mul_a),
        .i_mul_b (mul_b),
        .o_res   (alu_res),
        .o_prod  (mul_p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_in.valid) n_state = S_DAY_BACK;
            S_DAY_BACK:  n_state = S_DAY_REM;
            S_DAY_REM:   n_state = S_WDAY_BACK;
            S_WDAY_BACK: n_state = S_WDAY_REM;
            S_WDAY_REM:  n_state = S_HOUR_BACK;
            S_HOUR_BACK: n_state = S_HOUR_REM;
            S_HOUR_REM:  n_state = S_MIN_QUO;
            S_MIN_QUO:   n_state = S_MIN_BACK;
            S_MIN_BACK:  n_state = S_MIN_REM;
            S_MIN_REM:   n_state = S_YEAR;
            S_YEAR:      if (!alu_res.ge) n_state = S_MONTH;
            S_MONTH:     if (r_mon == LAST_MONTH || !alu_res.ge) n_state = S_DONE;
            S_DONE:      if (out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        // Hold each product for the step that follows
        r_prod <= mul_p;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) r_secs <= i_in.epoch_secs[REM_W-1:0];
            end
            S_DAY_BACK: begin
                r_days <= r_prod[DAY_Q_LSB +: DAY_W];
            end
            S_DAY_REM: begin
                r_rem <= alu_res.diff[REM_W-1:0];
            end
            S_WDAY_BACK: begin
            end
            S_WDAY_REM: begin
                r_wday <= (alu_res.diff[2:0] == 3'd0) ? WDAY_SAT : alu_res.diff[2:0];
            end
            S_HOUR_BACK: begin
                r_hour <= r_prod[HOUR_Q_LSB +: 5];
            end
            S_HOUR_REM: begin
                r_rem <= {5'd0, alu_res.diff[11:0]};
            end
            S_MIN_QUO: begin
            end
            S_MIN_BACK: begin
                r_min <= r_prod[MIN_Q_LSB +: 6];
            end
            S_MIN_REM: begin
                r_sec <= alu_res.diff[5:0];
                r_ofs <= '0;
            end
            S_YEAR: begin
                if (alu_res.ge) begin
                    r_days <= alu_res.diff[DAY_W-1:0];
                    r_ofs  <= r_ofs + 8'd1;
                end else begin
                    r_mon <= '0;
                end
            end
            S_MONTH: begin
                if (r_mon != LAST_MONTH && alu_res.ge) begin
                    r_days <= alu_res.diff[DAY_W-1:0];
                    r_mon  <= r_mon + 4'd1;
                end
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load_out) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_year  <= BASE_YEAR + {4'd0, r_ofs};
            r_o_month <= r_mon + 4'd1;
            r_o_day   <= r_days[4:0] + 5'd1;
            r_o_hour  <= r_hour;
            r_o_min   <= r_min;
            r_o_sec   <= r_sec;
            r_o_wday  <= r_wday;
        end
    end

    assign o_out.valid   = r_o_valid;
    assign o_out.year    = r_o_year;
    assign o_out.month   = r_o_month;
    assign o_out.day     = r_o_day;
    assign o_out.hour    = r_o_hour;
    assign o_out.minute  = r_o_min;
    assign o_out.sec     = r_o_sec;
    assign o_out.weekday = r_o_wday;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_DAY_BACK))
        else $error("accepted beat did not start the day division");

    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> ($past(r_state) == S_DONE))
        else $error("result valid rose outside the hand-over state");

    a_year_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_YEAR) |-> (r_ofs <= YEAR_OFS_MAX))
        else $error("year walk ran past the last reachable year");

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MONTH) |-> (r_mon <= LAST_MONTH && r_days < 16'd366))
        else $error("month walk out of range");

endmodule

`default_nettype wire

// File: design/e2d_alu.sv
`default_nettype none

module e2d_alu import e2d_pkg::*; (
    input  logic [ALU_W-1:0]   i_a,
    input  logic [ALU_W-1:0]   i_b,
    input  logic [MUL_A_W-1:0] i_mul_a,
    input  logic [MUL_B_W-1:0] i_mul_b,
    output t_alu_res           o_res,
    output logic [MUL_P_W-1:0] o_prod
);

    logic [ALU_W:0] sub;

    // Borrow out of the top bit means a < b
    assign sub        = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.ge   = ~sub[ALU_W];
    assign o_res.diff = sub[ALU_W-1:0];

    assign o_prod = {{MUL_B_W{1'b0}}, i_mul_a} * {{MUL_A_W{1'b0}}, i_mul_b};

endmodule

`default_nettype wire

// File: test/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned EPOCH_YEAR  = 2000;
    localparam int unsigned LAST_YEAR   = 2136;
    localparam int unsigned SECS_IN_DAY = 86400;
    localparam int unsigned RANDOM_ITEMS = 1300;
    localparam int unsigned DRAIN_EVERY  = 400;
    localparam int unsigned TAIL_CYCLES  = 300;
    localparam int unsigned CYCLE_LIMIT  = 3_000_000;
    localparam int unsigned MAX_REPORTS  = 10;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  sec;
        logic [2:0]  weekday;
    } t_date;

    // drain: hold the input until every outstanding date has come back
    typedef struct {
        logic [31:0] secs;
        bit          drain;
    } t_stim;

    logic clk;
    logic rst_n;

    e2d_in_if  in_if ();
    e2d_out_if out_if ();

    epoch_seconds_to_date_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_stim       secs_queue[$];
    t_date       pending_dates[$];
    int unsigned hold_cnt;
    int unsigned stall_cnt;
    bit          calm_in;
    bit          calm_out;
    int unsigned err_cnt;
    int unsigned beats_in;
    int unsigned dates_checked;
    int unsigned leap_days_seen;
    int unsigned cycle_cnt;
    bit          years_seen [EPOCH_YEAR:LAST_YEAR];

    function automatic int unsigned year_len(input int unsigned yr);
        if (yr % 4 != 0) return 365;
        if (yr % 100 != 0) return 366;
        return (yr % 400 == 0) ? 366 : 365;
    endfunction

    function automatic int unsigned mon_len(input int unsigned mon, input int unsigned yr);
        case (mon)
            2:            return (year_len(yr) == 366) ? 29 : 28;
            4, 6, 9, 11:  return 30;
            default:      return 31;
        endcase
    endfunction

    function automatic int unsigned year_start(input int unsigned yr);
        int unsigned days;
        days = 0;
        for (int unsigned y = EPOCH_YEAR; y < yr; y++) days += year_len(y);
        return days;
    endfunction

    function automatic t_date civil_date(input logic [31:0] secs);
        t_date       r;
        int unsigned s;
        int unsigned days;
        int unsigned yr;
        int unsigned mon;
        s        = secs;
        r.sec    = 6'(s % 60);
        s        = s / 60;
        r.minute = 6'(s % 60);
        s        = s / 60;
        r.hour   = 5'(s % 24);
        days     = s / 24;
        // day 0 was a Saturday
        r.weekday = 3'((days + 6) % 7 + 1);
        yr = EPOCH_YEAR;
        while (days >= year_len(yr)) begin
            days -= year_len(yr);
            yr++;
        end
        mon = 1;
        while (mon < 12 && days >= mon_len(mon, yr)) begin
            days -= mon_len(mon, yr);
            mon++;
        end
        r.year  = 12'(yr);
        r.month = 4'(mon);
        r.day   = 5'(days + 1);
        return r;
    endfunction

    function automatic int unsigned idle_len(input bit calm);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (calm) return 0;
        if (pick < 70) return $urandom_range(0, 3);
        if (pick < 95) return $urandom_range(4, 24);
        return $urandom_range(40, 250);
    endfunction

    function automatic logic [31:0] random_secs();
        int unsigned  pick;
        int unsigned  yr;
        longint       base;
        pick = $urandom_range(0, 9);
        if (pick < 5) return $urandom;
        if (pick < 7) return $urandom_range(0, 800 * SECS_IN_DAY);
        if (pick < 9) begin
            // straddle a new year: last day of one year, first of the next
            yr   = $urandom_range(EPOCH_YEAR + 1, LAST_YEAR);
            base = longint'(year_start(yr)) * SECS_IN_DAY - SECS_IN_DAY;
            return 32'(base + $urandom_range(0, 2 * SECS_IN_DAY - 1));
        end
        // around the end of February
        yr   = $urandom_range(EPOCH_YEAR, LAST_YEAR - 1);
        base = longint'(year_start(yr) + 58) * SECS_IN_DAY;
        return 32'(base + $urandom_range(0, 2 * SECS_IN_DAY - 1));
    endfunction

    function automatic void add_secs(input logic [31:0] secs);
        t_stim item;
        item.secs  = secs;
        item.drain = 1'b0;
        secs_queue.push_back(item);
    endfunction

    function automatic void add_drain();
        t_stim item;
        item.secs  = '0;
        item.drain = 1'b1;
        secs_queue.push_back(item);
    endfunction

    task automatic check_date();
        t_date got;
        t_date want;
        got = '{out_if.year, out_if.month, out_if.day, out_if.hour, out_if.minute,
                out_if.sec, out_if.weekday};
        if (pending_dates.size() == 0) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
                $display("%0t: unexpected result %0d-%0d-%0d %0d:%0d:%0d wd %0d", $realtime,
                         got.year, got.month, got.day, got.hour, got.minute, got.sec,
                         got.weekday);
            return;
        end
        want = pending_dates.pop_front();
        dates_checked++;
        if (got.year != want.year || got.month != want.month || got.day != want.day ||
            got.hour != want.hour || got.minute != want.minute || got.sec != want.sec ||
            got.weekday != want.weekday) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
                $display("%0t: exp %0d-%0d-%0d %0d:%0d:%0d/%0d got %0d-%0d-%0d %0d:%0d:%0d/%0d",
                         $realtime, want.year, want.month, want.day, want.hour, want.minute,
                         want.sec, want.weekday, got.year, got.month, got.day, got.hour,
                         got.minute, got.sec, got.weekday);
        end else begin
            years_seen[want.year] = 1'b1;
            if (want.month == 2 && want.day == 29) leap_days_seen++;
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d dates outstanding", cycle_cnt,
                     pending_dates.size());
            $display("epoch_seconds_to_date_top verification failed");
            $finish;
        end
    end

    // Input driver: present one beat at a time from secs_queue
    always @(posedge clk) begin
        if (!rst_n) begin
            in_if.valid      <= 1'b0;
            in_if.epoch_secs <= '0;
            hold_cnt         <= 0;
        end else if (!in_if.valid || in_if.ready) begin
            if (in_if.valid) begin
                pending_dates.push_back(civil_date(in_if.epoch_secs));
                beats_in++;
            end
            if (hold_cnt != 0) begin
                in_if.valid <= 1'b0;
                hold_cnt    <= hold_cnt - 1;
            end else if (secs_queue.size() != 0 && secs_queue[0].drain) begin
                in_if.valid <= 1'b0;
                if (pending_dates.size() == 0) void'(secs_queue.pop_front());
            end else if (secs_queue.size() != 0) begin
                in_if.valid      <= 1'b1;
                in_if.epoch_secs <= secs_queue[0].secs;
                void'(secs_queue.pop_front());
                hold_cnt <= idle_len(calm_in);
                if ($urandom_range(0, 39) == 0) calm_in <= !calm_in;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Output monitor: check each beat, stall ready at random
    always @(posedge clk) begin
        if (!rst_n) begin
            out_if.ready <= 1'b0;
            stall_cnt    <= 0;
        end else begin
            if (out_if.valid && out_if.ready) check_date();
            if (stall_cnt != 0) begin
                out_if.ready <= 1'b0;
                stall_cnt    <= stall_cnt - 1;
            end else if (!calm_out && $urandom_range(0, 5) == 0) begin
                out_if.ready <= 1'b0;
                stall_cnt    <= idle_len(1'b0);
            end else begin
                out_if.ready <= 1'b1;
            end
            if ($urandom_range(0, 199) == 0) calm_out <= !calm_out;
        end
    end

    initial begin
        int unsigned years_hit;
        rst_n            = 1'b0;
        in_if.valid      = 1'b0;
        in_if.epoch_secs = '0;
        out_if.ready     = 1'b0;
        calm_in          = 1'b0;
        calm_out         = 1'b0;
        err_cnt          = 0;
        beats_in         = 0;
        dates_checked    = 0;
        leap_days_seen   = 0;
        cycle_cnt        = 0;
        years_hit        = 0;
        foreach (years_seen[y]) years_seen[y] = 1'b0;

        // field extremes, weekday wrap, leap day, year and century boundaries
        add_secs(32'd0);
        add_secs(32'd59);
        add_secs(32'd60);
        add_secs(32'd3599);
        add_secs(32'd3600);
        add_secs(32'd86399);
        add_secs(32'd86400);
        add_secs(32'd5097599);
        add_secs(32'd5097600);
        add_secs(32'd5184000);
        add_secs(32'd31536000);
        add_secs(32'd31622399);
        add_secs(32'd31622400);
        add_secs(32'd3155759999);
        add_secs(32'd3155760000);
        add_secs(32'd3160771200);
        add_secs(32'd3160857600);
        add_secs(32'hAAAAAAAA);
        add_secs(32'h55555555);
        add_secs(32'hFFFFFFFF);
        add_drain();
        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            add_secs(random_secs());
            if (n % DRAIN_EVERY == DRAIN_EVERY - 1) add_drain();
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (secs_queue.size() != 0 || in_if.valid) @(posedge clk);
        while (pending_dates.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        foreach (years_seen[y]) if (years_seen[y]) years_hit++;
        $display("Converted %0d beats, checked %0d dates in %0d cycles", beats_in,
                 dates_checked, cycle_cnt);
        $display("Dates fell in %0d distinct years, %0d on 29 February; %0d errors",
                 years_hit, leap_days_seen, err_cnt);
        if (err_cnt == 0) begin
            $display("epoch_seconds_to_date_top verification clean");
        end else begin
            $display("epoch_seconds_to_date_top verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
